// ===== rtl/rps_pkg.sv =====
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types and constants for the rotation palindrome search block:
// request payloads, microcode fields and the status/control bundles.
// ----------------------------------------------------------------------------
package rps_pkg;

  localparam int MAX_LEN_DEF = 64;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       out_last;
    logic       found;
  } out_req_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_KINIT,
    OP_PINIT,
    OP_STEP_PAIR,
    OP_DEC_K,
    OP_EINIT,
    OP_PUSH
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_IN_LAST,
    C_PAIRS_DONE,
    C_MATCH,
    C_K_NONZERO,
    C_OUT_BUSY,
    C_EMIT_END
  } cond_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_KINIT,
    S_PINIT,
    S_CHECK,
    S_CMP,
    S_NEXTK,
    S_NONE,
    S_EINIT,
    S_EREAD,
    S_EPUSH,
    S_ECHK,
    S_CLEAR
  } step_t;

  typedef struct packed {
    op_t   op;
    logic  push_found;
    logic  clear_len;
    cond_t cond;
    step_t jump;
    step_t next;
  } uword_t;

  typedef struct packed {
    logic in_last;
    logic pairs_done;
    logic match;
    logic k_nonzero;
    logic out_busy;
    logic emit_end;
  } status_t;

endpackage

// ===== rtl/rps_sequencer.sv =====
// ----------------------------------------------------------------------------
// rps_sequencer
// Microcode store and step counter. Each step selects a datapath operation
// and a jump condition; the step counter follows the jump or next field.
// ----------------------------------------------------------------------------
module rps_sequencer import rps_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output uword_t  uword
);

  step_t pc;
  step_t pc_next;
  logic  take;

  always_comb begin
    uword = '{op: OP_NONE, push_found: 1'b0, clear_len: 1'b0, cond: C_NEVER,
              jump: S_LOAD, next: S_LOAD};
    unique case (pc)
      S_LOAD:  uword = '{OP_LOAD,      1'b0, 1'b0, C_IN_LAST,    S_KINIT, S_LOAD};
      S_KINIT: uword = '{OP_KINIT,     1'b0, 1'b0, C_NEVER,      S_LOAD,  S_PINIT};
      S_PINIT: uword = '{OP_PINIT,     1'b0, 1'b0, C_NEVER,      S_LOAD,  S_CHECK};
      S_CHECK: uword = '{OP_NONE,      1'b0, 1'b0, C_PAIRS_DONE, S_EINIT, S_CMP};
      S_CMP:   uword = '{OP_STEP_PAIR, 1'b0, 1'b0, C_MATCH,      S_CHECK, S_NEXTK};
      S_NEXTK: uword = '{OP_DEC_K,     1'b0, 1'b0, C_K_NONZERO,  S_PINIT, S_NONE};
      S_NONE:  uword = '{OP_PUSH,      1'b0, 1'b0, C_OUT_BUSY,   S_NONE,  S_CLEAR};
      S_EINIT: uword = '{OP_EINIT,     1'b0, 1'b0, C_NEVER,      S_LOAD,  S_EREAD};
      S_EREAD: uword = '{OP_NONE,      1'b0, 1'b0, C_NEVER,      S_LOAD,  S_EPUSH};
      S_EPUSH: uword = '{OP_PUSH,      1'b1, 1'b0, C_OUT_BUSY,   S_EPUSH, S_ECHK};
      S_ECHK:  uword = '{OP_NONE,      1'b0, 1'b0, C_EMIT_END,   S_CLEAR, S_EREAD};
      S_CLEAR: uword = '{OP_NONE,      1'b0, 1'b1, C_NEVER,      S_LOAD,  S_LOAD};
      default: uword = '{OP_NONE,      1'b0, 1'b1, C_NEVER,      S_LOAD,  S_LOAD};
    endcase
  end

  always_comb begin
    unique case (uword.cond)
      C_NEVER:      take = 1'b0;
      C_IN_LAST:    take = status.in_last;
      C_PAIRS_DONE: take = status.pairs_done;
      C_MATCH:      take = status.match;
      C_K_NONZERO:  take = status.k_nonzero;
      C_OUT_BUSY:   take = status.out_busy;
      C_EMIT_END:   take = status.emit_end;
      default:      take = 1'b0;
    endcase
    pc_next = take ? uword.jump : uword.next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== rtl/rps_datapath.sv =====
// ----------------------------------------------------------------------------
// rps_datapath
// Symbol store with two registered read ports, rotation and pair pointers,
// and the output register. Operations are selected by the microcode word.
// ----------------------------------------------------------------------------
module rps_datapath import rps_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  uword_t   uword,
  output status_t  status,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_req
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);

  logic [7:0]    mem [MAX_LEN];
  logic [7:0]    rd_a;
  logic [7:0]    rd_b;
  logic [LW-1:0] len;
  logic [LW-1:0] cnt;
  logic [AW-1:0] k;
  logic [AW-1:0] lo;
  logic [AW-1:0] hi;
  logic [AW-1:0] a;
  logic [AW-1:0] b;
  logic [LW-1:0] len_m1_w;
  logic [AW-1:0] len_m1;
  logic [AW-1:0] a_inc;
  logic [AW-1:0] b_dec;
  logic          accept;
  logic          wr_en;
  logic          out_free;
  logic          push;

  assign len_m1_w = len - 1'b1;
  assign len_m1   = len_m1_w[AW-1:0];
  assign a_inc    = (a == len_m1) ? '0 : a + 1'b1;
  assign b_dec    = (b == '0) ? len_m1 : b - 1'b1;
  assign in_stall = (uword.op != OP_LOAD);
  assign accept   = in_valid && !in_stall;
  assign wr_en    = accept && (len < LW'(MAX_LEN));
  assign out_free = !out_valid || !out_stall;
  assign push     = (uword.op == OP_PUSH) && out_free;

  assign status.in_last    = accept && in_req.last;
  assign status.pairs_done = !(lo < hi);
  assign status.match      = (rd_a == rd_b);
  assign status.k_nonzero  = (k != '0);
  assign status.out_busy   = !out_free;
  assign status.emit_end   = (cnt == len);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[len[AW-1:0]] <= in_req.symbol;
    end
    rd_a <= mem[a];
    rd_b <= mem[b];
  end

  always_ff @(posedge clk) begin
    case (uword.op)
      OP_KINIT: begin
        k <= len_m1;
      end
      OP_PINIT: begin
        lo <= '0;
        hi <= len_m1;
        a  <= k;
        b  <= (k == '0) ? len_m1 : k - 1'b1;
      end
      OP_STEP_PAIR: begin
        lo <= lo + 1'b1;
        hi <= hi - 1'b1;
        a  <= a_inc;
        b  <= b_dec;
      end
      OP_DEC_K: begin
        k <= k - 1'b1;
      end
      OP_EINIT: begin
        a   <= k;
        cnt <= '0;
      end
      OP_PUSH: begin
        if (push && uword.push_found) begin
          a   <= a_inc;
          cnt <= cnt + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (uword.clear_len) begin
        len <= '0;
      end else if (wr_en) begin
        len <= len + 1'b1;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (uword.push_found) begin
        out_req.out_symbol <= rd_a;
        out_req.out_last   <= ((cnt + 1'b1) == len);
        out_req.found      <= 1'b1;
      end else begin
        out_req.out_symbol <= '0;
        out_req.out_last   <= 1'b1;
        out_req.found      <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/rotation_palindrome_search.sv =====
// After the request flagged last, each candidate rotation runs a pointer
// set-up step, then a check step and a compare step per pair; the result
// leaves through a read, a push and an end-check step per symbol, set by
// the single-step sequencer and the registered store reads. Symbols load
// at one per cycle while in the load step. Reset is synchronous and clears
// length, sequencer and output valid; the symbol store is not cleared.
// ----------------------------------------------------------------------------
// rotation_palindrome_search
// Loads a string and emits its first palindromic rotation, trying starts
// from the last position down to zero, or one not-found result.
// ----------------------------------------------------------------------------
module rotation_palindrome_search import rps_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_req
);

  uword_t  uword;
  status_t status;

  rps_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uword  (uword)
  );

  rps_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .uword     (uword),
    .status    (status),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

endmodule

// ===== rtl/rps_checker.sv =====
// ----------------------------------------------------------------------------
// rps_checker
// Port-level checks for the rotation palindrome search block, bound to the
// top level.
// ----------------------------------------------------------------------------
module rps_checker import rps_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input in_req_t  in_req,
  input logic     out_valid,
  input logic     out_stall,
  input out_req_t out_req
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_req))
    else $error("Stalled output request changed.");

  a_not_found_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_req.found |-> out_req.out_last && (out_req.out_symbol == 8'd0))
    else $error("Not-found result is malformed.");

  a_busy_during_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_req.out_last |-> in_stall)
    else $error("Input accepted while a result run is in progress.");

  a_search_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_req.last |=> in_stall)
    else $error("Input not stalled after the final symbol.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid after reset.");

endmodule

bind rotation_palindrome_search rps_checker u_rps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_req   (out_req)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for rotation_palindrome_search. Strings are sent one symbol per
// request, and the request flagged last starts the search. A scoreboard
// predicts the first palindromic rotation, or the single not-found result,
// and checks every result field by field in order. The run starts with short
// directed strings, then mostly mirrored and rotated strings, strings over a
// two-symbol alphabet, fully random strings and a few that overflow the
// store. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb import rps_pkg::*; ();

  localparam int MAX_LEN = MAX_LEN_DEF;

  typedef enum int {
    STYLE_RANDOM,
    STYLE_TWO_SYMBOL,
    STYLE_ROTATED_PALINDROME
  } word_style_t;

  class rotation_search_board;
    logic [7:0]  chars [MAX_LEN];
    int unsigned str_len;
    out_req_t    rotation_q[$];
    int unsigned mismatches;

    function new();
      str_len = 0;
      mismatches = 0;
    endfunction

    function void note_request(in_req_t req);
      int       n;
      int       start;
      int       lo;
      int       hi;
      bit       pal;
      out_req_t want;
      if (str_len < MAX_LEN) begin
        chars[str_len] = req.symbol;
        str_len++;
      end
      if (!req.last) return;
      n = str_len;
      str_len = 0;
      start = -1;
      // Starts from n-1 down to 1, then 0, which is a plain descending scan.
      for (int k = n - 1; k >= 0 && start < 0; k--) begin
        pal = 1'b1;
        lo = 0;
        hi = n - 1;
        while (lo < hi) begin
          if (chars[(k + lo) % n] != chars[(k + hi) % n]) pal = 1'b0;
          lo++;
          hi--;
        end
        if (pal) start = k;
      end
      if (start < 0) begin
        want.out_symbol = 8'h00;
        want.out_last = 1'b1;
        want.found = 1'b0;
        rotation_q.push_back(want);
      end else begin
        for (int k = 0; k < n; k++) begin
          want.out_symbol = chars[(start + k) % n];
          want.out_last = (k == n - 1);
          want.found = 1'b1;
          rotation_q.push_back(want);
        end
      end
    endfunction

    function void check_result(out_req_t got);
      out_req_t want;
      if (rotation_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: symbol %02h last %0b found %0b",
                   got.out_symbol, got.out_last, got.found);
        return;
      end
      want = rotation_q.pop_front();
      if (got.out_symbol !== want.out_symbol || got.out_last !== want.out_last ||
          got.found !== want.found) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected symbol %02h last %0b found %0b, got %02h %0b %0b",
                   want.out_symbol, want.out_last, want.found,
                   got.out_symbol, got.out_last, got.found);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_req_t out_req;

  rotation_search_board board = new();
  logic [7:0]           word_q[$];
  int                   send_idle_pct = 0;
  int                   stall_pct = 0;
  int                   items_sent = 0;

  rotation_palindrome_search dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_req  (out_req)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) board.note_request(in_req);
    if (!rst && out_valid && !out_stall) board.check_result(out_req);
  end

  task automatic send_request(logic [7:0] sym, logic last_flag);
    in_req_t req;
    req.symbol = sym;
    req.last = last_flag;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_word();
    for (int i = 0; i < word_q.size(); i++)
      send_request(word_q[i], i == word_q.size() - 1);
  endtask

  task automatic build_word(int len, word_style_t style);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    int         shift;
    int         pick;
    a = 8'($urandom_range(255));
    b = 8'($urandom_range(255));
    c = 8'($urandom_range(255));
    word_q.delete();
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(2);
      case (style)
        STYLE_RANDOM:     word_q.push_back(8'($urandom_range(255)));
        STYLE_TWO_SYMBOL: word_q.push_back(pick == 0 ? a : b);
        default: begin
          if ($urandom_range(3) == 0) word_q.push_back(8'($urandom_range(255)));
          else word_q.push_back(pick == 0 ? a : (pick == 1 ? b : c));
        end
      endcase
    end
    if (style == STYLE_ROTATED_PALINDROME) begin
      for (int i = 0; i < len / 2; i++) word_q[len - 1 - i] = word_q[i];
      shift = $urandom_range(len - 1);
      repeat (shift) word_q.push_back(word_q.pop_front());
    end
  endtask

  task automatic send_bytes(logic [7:0] s [$]);
    word_q = s;
    send_word();
  endtask

  initial begin
    int          len;
    int          roll;
    int          phase_start;
    word_style_t style;
    rst = 1'b1;
    in_valid = 1'b0;
    in_req = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_bytes('{8'h00});
    send_bytes('{8'hFF});
    send_bytes('{8'h00, 8'hFF});
    send_bytes('{8'h61, 8'h61, 8'h62});
    send_bytes('{8'h55, 8'h55, 8'h55});
    send_bytes('{8'h62, 8'h63, 8'h62, 8'h61, 8'h61});
    send_bytes('{8'h78, 8'h79, 8'h7A});
    send_bytes('{8'hAA, 8'h55, 8'hAA, 8'h55});

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      phase_start = items_sent;
      if (phase == 0) begin
        // Full-length palindrome rotation, then the same with extra symbols
        // that the store drops, including the final one.
        build_word(MAX_LEN, STYLE_ROTATED_PALINDROME);
        send_word();
        build_word(MAX_LEN, STYLE_ROTATED_PALINDROME);
        repeat (5) word_q.push_back(8'($urandom_range(255)));
        send_word();
      end
      while (items_sent - phase_start < 50) begin
        roll = $urandom_range(99);
        if (roll < 3) len = $urandom_range(MAX_LEN + 8, MAX_LEN + 1);
        else if (roll < 7) len = $urandom_range(MAX_LEN, 30);
        else len = $urandom_range(10, 1);
        roll = $urandom_range(99);
        if (roll < 55) style = STYLE_ROTATED_PALINDROME;
        else if (roll < 80) style = STYLE_TWO_SYMBOL;
        else style = STYLE_RANDOM;
        build_word(len, style);
        send_word();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (board.rotation_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (board.mismatches == 0 && board.rotation_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #16000000;
    $display("FAILURE");
    $finish;
  end

endmodule
